/* rtl/fifo_queue_with_key_search_assert.svh */
// Assertion helpers. Each expects clk and arst_n in the scope of the module that uses it.
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_ASSERT_SVH

// Same-cycle implication
`define FQKS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FQKS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fqks_pkg.sv */
`default_nettype none
package fqks_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 48;
	localparam int DATA_W = 32;
	localparam int POS_W = 5;
	localparam int OP_W = 2;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  out_key;
		logic [DATA_W-1:0] out_data;
		logic [POS_W-1:0]  position;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

endpackage
`default_nettype wire

/* rtl/fqks_front.sv */
`default_nettype none
module fqks_front
	import fqks_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   in_opcode,
	input  wire logic [KEY_W-1:0]  in_key,
	input  wire logic [DATA_W-1:0] in_data,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output cmd_t                   cmd
);

	// two-entry request queue between the port and the engine
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = slot_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: in_opcode, key: in_key, data: in_data};
		end
	end

endmodule
`default_nettype wire

/* rtl/fqks_engine.sv */
`default_nettype none
`include "fifo_queue_with_key_search_assert.svh"
module fqks_engine
	import fqks_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	localparam int SUM_W = IDX_W + 1;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEQ = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_SHIFT = 2'd3;

	// circular store, logical slot i lives at head + i
	entry_t mem [DEPTH];
	entry_t rd_data_q;

	logic [1:0]        state_q, state_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  iss_q, iss_d;
	logic              rd_vld_s1, rd_vld_d;
	logic [CNT_W-1:0]  rd_idx_s1, rd_idx_d;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic              res_valid_q;
	res_t              res_q, res_d;
	logic              res_load;
	logic              rd_en, wr_en;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	entry_t            wr_data;
	logic              match;
	logic              last_cmp;
	logic [CNT_W-1:0]  dst_idx;

	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
			input logic [IDX_W-1:0] i);
		logic [SUM_W-1:0] s;
		s = {1'b0, h} + {1'b0, i};
		if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	assign match = rd_vld_s1 && (rd_data_q.key == key_q)
		&& ((op_q == OP_SEARCH) || (rd_data_q.data == data_q));
	assign last_cmp = rd_vld_s1 && (rd_idx_s1 == count_q - CNT_W'(1));
	assign dst_idx = rd_idx_s1 - CNT_W'(1);

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		iss_d = iss_q;
		rd_vld_d = 1'b0;
		rd_idx_d = rd_idx_s1;
		cmd_ready = 1'b0;
		res_load = 1'b0;
		res_d = '0;
		res_d.status = STAT_MISSING;
		rd_en = 1'b0;
		rd_addr = head_q;
		wr_en = 1'b0;
		wr_addr = head_q;
		wr_data = rd_data_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_valid_q) begin
					cmd_ready = 1'b1;
					case (cmd.op)
						OP_ENQUEUE: begin
							res_load = 1'b1;
							if (count_q < CNT_W'(DEPTH)) begin
								wr_en = 1'b1;
								wr_addr = phys(head_q, count_q[IDX_W-1:0]);
								wr_data = '{key: cmd.key, data: cmd.data};
								count_d = count_q + CNT_W'(1);
								res_d.status = STAT_OK;
							end else begin
								res_d.status = STAT_FULL;
							end
						end
						OP_DEQUEUE: begin
							if (count_q == '0) begin
								res_load = 1'b1;
							end else begin
								rd_en = 1'b1;
								rd_addr = head_q;
								state_d = ST_DEQ;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_load = 1'b1;
							end else begin
								iss_d = '0;
								state_d = ST_SCAN;
							end
						end
					endcase
				end
			end
			ST_DEQ: begin
				res_load = 1'b1;
				res_d.status = STAT_OK;
				res_d.out_key = rd_data_q.key;
				res_d.out_data = rd_data_q.data;
				head_d = phys(head_q, IDX_W'(1));
				count_d = count_q - CNT_W'(1);
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (match) begin
					if (op_q == OP_SEARCH) begin
						res_load = 1'b1;
						res_d.status = STAT_OK;
						res_d.out_key = rd_data_q.key;
						res_d.out_data = rd_data_q.data;
						res_d.position = POS_W'(rd_idx_s1 + CNT_W'(1));
						state_d = ST_IDLE;
					end else if (last_cmp) begin
						res_load = 1'b1;
						res_d.status = STAT_OK;
						count_d = count_q - CNT_W'(1);
						state_d = ST_IDLE;
					end else begin
						// close the gap: move each later entry one slot toward the head
						iss_d = rd_idx_s1 + CNT_W'(1);
						state_d = ST_SHIFT;
					end
				end else if (last_cmp) begin
					res_load = 1'b1;
					state_d = ST_IDLE;
				end else if (iss_q < count_q) begin
					rd_en = 1'b1;
					rd_addr = phys(head_q, iss_q[IDX_W-1:0]);
					rd_vld_d = 1'b1;
					rd_idx_d = iss_q;
					iss_d = iss_q + CNT_W'(1);
				end
			end
			ST_SHIFT: begin
				if (rd_vld_s1) begin
					wr_en = 1'b1;
					wr_addr = phys(head_q, dst_idx[IDX_W-1:0]);
					wr_data = rd_data_q;
				end
				if (iss_q < count_q) begin
					rd_en = 1'b1;
					rd_addr = phys(head_q, iss_q[IDX_W-1:0]);
					rd_vld_d = 1'b1;
					rd_idx_d = iss_q;
					iss_d = iss_q + CNT_W'(1);
				end else if (!rd_vld_s1) begin
					res_load = 1'b1;
					res_d.status = STAT_OK;
					count_d = count_q - CNT_W'(1);
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			iss_q <= '0;
			rd_vld_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
			iss_q <= iss_d;
			rd_vld_s1 <= rd_vld_d;
			if (res_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_d;
		if (cmd_ready) begin
			op_q <= cmd.op;
			key_q <= cmd.key;
			data_q <= cmd.data;
		end
		if (res_load) res_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`FQKS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH),
		"fill count above depth")
	`FQKS_ASSERT_IMP(a_load_free, res_load, !res_valid_q,
		"result overwritten before it was taken")
	`FQKS_ASSERT_IMP(a_rd_state, rd_vld_s1, (state_q == ST_SCAN) || (state_q == ST_SHIFT),
		"read pipeline busy outside a scan or shift")
	`FQKS_ASSERT_NXT(a_enq_grow,
		cmd_ready && (cmd.op == OP_ENQUEUE) && (count_q < CNT_W'(DEPTH)),
		count_q == $past(count_q) + CNT_W'(1), "enqueue did not grow the queue")

endmodule
`default_nettype wire

/* rtl/fifo_queue_with_key_search.sv */
// Ordered queue of DEPTH (16) key/data entries with enqueue, dequeue, search by key and
// delete of an exact key/data match; every request yields exactly one result. Requests
// pass through a two-entry queue into an engine that owns a one-read, one-write store
// kept as a ring, so the port takes new requests while the engine works and a result
// waits. An enqueue writes the store at once, a dequeue reads the head through the store's
// registered read port, a search compares one entry per cycle with the key (stopping at the
// first match), and a delete scans likewise, then moves each later entry one slot toward
// the head; the result then sits in a result register until the receiver takes it.
`default_nettype none
module fifo_queue_with_key_search
	import fqks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // item_key[47:0], item_data[79:48]
	input  wire logic [1:0]  s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,  // out_key[47:0], out_data[79:48], position[84:80]
	output logic [1:0]       m_axis_tuser   // status
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	res_t res;

	fqks_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_key    (s_axis_tdata[47:0]),
		.in_data   (s_axis_tdata[79:48]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	fqks_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {3'b000, res.position, res.out_data, res.out_key};
	assign m_axis_tuser = res.status;

endmodule
`default_nettype wire

/* dv/queue_result_checker.sv */
`default_nettype none
module queue_result_checker
	import fqks_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // item_key[47:0], item_data[79:48]
	input  wire logic [1:0]  s_axis_tuser,  // opcode
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [87:0] m_axis_tdata,  // out_key[47:0], out_data[79:48], position[84:80]
	input  wire logic [1:0]  m_axis_tuser,  // status
	output int               fail_count,
	output int               pending,
	output int               result_count,
	output int               full_count,
	output int               missing_count
);
	timeunit 1ns;
	timeprecision 1ps;

	entry_t held_entries[$];
	res_t   expected_results[$];
	cmd_t   req;
	res_t   want;

	// Apply one request to the shadow queue and return the result it must produce.
	function automatic res_t predict_queue_op(input cmd_t c);
		res_t   r;
		entry_t e;
		r = '0;
		r.status = STAT_MISSING;
		case (c.op)
			OP_ENQUEUE: begin
				if (held_entries.size() < DEPTH) begin
					e.key = c.key;
					e.data = c.data;
					held_entries.push_back(e);
					r.status = STAT_OK;
				end else begin
					r.status = STAT_FULL;
				end
			end
			OP_DEQUEUE: begin
				if (held_entries.size() > 0) begin
					e = held_entries.pop_front();
					r.out_key = e.key;
					r.out_data = e.data;
					r.status = STAT_OK;
				end
			end
			OP_SEARCH: begin
				for (int i = 0; i < held_entries.size(); i++) begin
					if (held_entries[i].key == c.key) begin
						r.out_key = held_entries[i].key;
						r.out_data = held_entries[i].data;
						r.position = POS_W'(i + 1);
						r.status = STAT_OK;
						break;
					end
				end
			end
			default: begin
				for (int i = 0; i < held_entries.size(); i++) begin
					if (held_entries[i].key == c.key && held_entries[i].data == c.data) begin
						held_entries.delete(i);
						r.status = STAT_OK;
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_entries.delete();
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			result_count = 0;
			full_count = 0;
			missing_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				req.op = s_axis_tuser;
				req.key = s_axis_tdata[47:0];
				req.data = s_axis_tdata[79:48];
				expected_results.push_back(predict_queue_op(req));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request outstanding, got status %0d",
						$time, m_axis_tuser);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 64'(want.status), 64'(m_axis_tuser));
					check_field("out_key", 64'(want.out_key), 64'(m_axis_tdata[47:0]));
					check_field("out_data", 64'(want.out_data), 64'(m_axis_tdata[79:48]));
					check_field("position", 64'(want.position), 64'(m_axis_tdata[84:80]));
					result_count++;
					if (want.status == STAT_FULL)
						full_count++;
					if (want.status == STAT_MISSING)
						missing_count++;
				end
			end
			pending = expected_results.size();
		end
	end

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb
	import fqks_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;   // item_key[47:0], item_data[79:48]
	logic [1:0]  s_axis_tuser;   // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;   // out_key[47:0], out_data[79:48], position[84:80]
	logic [1:0]  m_axis_tuser;   // status

	int fail_count;
	int pending;
	int result_count;
	int full_count;
	int missing_count;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_requests;
	int holds_done;
	int sent_by_op[4];

	logic [KEY_W-1:0]  key_pool[8];
	logic [DATA_W-1:0] data_pool[3];

	fifo_queue_with_key_search u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	queue_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.result_count  (result_count),
		.full_count    (full_count),
		.missing_count (missing_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [KEY_W-1:0] dir_key(input int i);
		if (i == 0)
			return '0;
		if (i == 1)
			return '1;
		// share a key between two entries with different data
		if (i == 5)
			return 48'h1234_0000_0000 + 48'd3;
		return 48'h1234_0000_0000 + KEY_W'(i);
	endfunction

	function automatic logic [DATA_W-1:0] dir_data(input int i);
		if (i == 0)
			return '0;
		if (i == 1)
			return '1;
		return 32'hD000_0000 | DATA_W'(i);
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input bit grow);
		int roll;
		roll = $urandom_range(0, 99);
		if (grow) begin
			if (roll < 50)
				return OP_ENQUEUE;
			if (roll < 62)
				return OP_DEQUEUE;
			if (roll < 82)
				return OP_SEARCH;
			return OP_DELETE;
		end
		if (roll < 15)
			return OP_ENQUEUE;
		if (roll < 55)
			return OP_DEQUEUE;
		if (roll < 75)
			return OP_SEARCH;
		return OP_DELETE;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [63:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(0, 99) < 80)
			return key_pool[$urandom_range(0, 7)];
		return w[KEY_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		if ($urandom_range(0, 99) < 80)
			return data_pool[$urandom_range(0, 2)];
		return $urandom;
	endfunction

	// Offer one request and hold it until accepted, then, with probability tx_idle_pct, idle for a random gap.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [DATA_W-1:0] data);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {data, key};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_by_op[op]++;
		gap = 0;
		if ($urandom_range(0, 99) < tx_idle_pct)
			gap = pick_idle_len();
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (400)
					@(negedge clk);
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 99) < rx_stall_pct)
					stall_left = pick_idle_len();
			end
		end
	end

	initial begin
		#6_000_000;
		$display("%0t: timeout, %0d results still outstanding", $time, pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		bit grow;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ENQUEUE;
		tx_idle_pct = 30;
		rx_stall_pct = 30;
		hold_requests = 0;
		holds_done = 0;
		foreach (sent_by_op[i])
			sent_by_op[i] = 0;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		foreach (data_pool[i])
			data_pool[i] = $urandom;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue
		send_request(OP_DEQUEUE, '0, '0);
		send_request(OP_SEARCH, dir_key(2), '0);
		send_request(OP_DELETE, dir_key(2), dir_data(2));
		// fill to the brim, then overflow
		for (int i = 0; i < DEPTH; i++)
			send_request(OP_ENQUEUE, dir_key(i), dir_data(i));
		send_request(OP_ENQUEUE, '1, '1);
		send_request(OP_SEARCH, dir_key(1), '0);
		send_request(OP_SEARCH, dir_key(3), '1);
		send_request(OP_SEARCH, dir_key(DEPTH - 1), '0);
		send_request(OP_SEARCH, 48'h0000_0000_0BAD, '0);
		send_request(OP_DELETE, dir_key(1), dir_data(1));
		// key of the first duplicate, data of the second
		send_request(OP_DELETE, dir_key(3), dir_data(5));
		send_request(OP_DELETE, dir_key(2), dir_data(3));
		send_request(OP_DELETE, dir_key(DEPTH - 1), dir_data(DEPTH - 1));
		send_request(OP_DEQUEUE, '0, '0);

		for (int blk = 0; blk < 16; blk++) begin
			grow = (blk % 2) == 0;
			case (blk % 4)
				0: begin
					tx_idle_pct = 20;
					rx_stall_pct = 20;
				end
				1: begin
					tx_idle_pct = 50;
					rx_stall_pct = 10;
				end
				2: begin
					tx_idle_pct = 10;
					rx_stall_pct = 50;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
			endcase
			// back up the output while requests keep coming
			if (blk == 4) begin
				tx_idle_pct = 0;
				hold_requests++;
			end
			repeat (60)
				send_request(pick_op(grow), pick_key(), pick_data());
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (50)
			@(posedge clk);

		$display("Sent %0d enqueue, %0d dequeue, %0d search and %0d delete requests",
			sent_by_op[OP_ENQUEUE], sent_by_op[OP_DEQUEUE], sent_by_op[OP_SEARCH],
			sent_by_op[OP_DELETE]);
		$display("Checked %0d results: %0d dropped on full, %0d empty or not found",
			result_count, full_count, missing_count);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
